// File: hdl/cpct_pkg.sv
// Shared constants and types of the collider pair contact tracker.
package cpct_pkg;

    localparam int MAX_COLLIDERS = 64;
    localparam int ID_W          = $clog2(MAX_COLLIDERS);

    localparam int POS_W  = 32;
    localparam int RAW_W  = 16;
    localparam int SIZE_W = 23;   // raw * 100
    localparam int SUM_W  = 24;   // sum of two scaled sizes
    localparam int GEO_W  = 36;   // doubled coordinates and their differences
    localparam int SQ_W   = 2 * SUM_W;

    localparam logic [6:0] SIZE_SCALE = 7'd100;

    localparam logic [1:0] SHAPE_RECT   = 2'd0;
    localparam logic [1:0] SHAPE_CIRCLE = 2'd1;

    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_ENTER = 2'd1;
    localparam logic [1:0] EV_STAY  = 2'd2;
    localparam logic [1:0] EV_EXIT  = 2'd3;

    localparam int S_TDATA_W = 208;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 64;
    localparam int M_TUSER_W = 3;

    typedef struct packed {
        logic            clear;       // write a zero row at clear_addr
        logic [ID_W-1:0] clear_addr;
        logic            load;        // capture input transfer, read contact row
        logic            finish;      // update contact row, load result register
    } cpct_cmd_t;

endpackage

// File: hdl/collider_pair_contact_tracker_top.sv
// Top level of the collider pair contact tracker.
//
//  channel | dir | handshake          | content
//  s_      | in  | s_tvalid/s_tready  | one collider pair per transfer
//  m_      | out | m_tvalid/m_tready  | contact event, overlap flag, push-out depth
//
// The input transfer edge captures the pair; the result register loads after
// the scale, sums, differences, squares and compare steps, together with the
// contact row update. s_tready is high only while no item is in flight. The
// result register lets the next pair in while a result waits; the row update
// stalls until it is free.
// After reset a sweep clears the contact table, one row per cycle, all
// MAX_COLLIDERS (64) rows, with s_tready low.
module collider_pair_contact_tracker_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // left_id, right_id, left_pos_x, left_pos_y, left_size_w, left_size_h,
    // right_pos_x, right_pos_y, right_size_w, right_size_h, zero pad
    input  logic [cpct_pkg::S_TDATA_W-1:0]  s_tdata,
    // left_shape, right_shape
    input  logic [cpct_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // depth_x, depth_y
    output logic [cpct_pkg::M_TDATA_W-1:0]  m_tdata,
    // contact_event, overlapping
    output logic [cpct_pkg::M_TUSER_W-1:0]  m_tuser
);

    cpct_pkg::cpct_cmd_t cmd;

    cpct_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    cpct_dp u_dp (
        .aclk    (aclk),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // one item in flight at a time
    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item is in flight");

    a_no_hit_event: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[2]) |->
        (m_tuser[1:0] == cpct_pkg::EV_NONE || m_tuser[1:0] == cpct_pkg::EV_EXIT))
        else $error("enter or stay without overlap");

    a_hit_event: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[2]) |->
        (m_tuser[1:0] == cpct_pkg::EV_ENTER || m_tuser[1:0] == cpct_pkg::EV_STAY))
        else $error("none or exit with overlap");

    a_depth_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[2]) |-> (m_tdata == '0))
        else $error("depth reported without overlap");

endmodule

// File: hdl/cpct_ctrl.sv
// Controller: table clear sweep, item sequencing and result valid.
module cpct_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output cpct_pkg::cpct_cmd_t cmd
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SCALE = 3'd2;
    localparam logic [2:0] ST_SUM   = 3'd3;
    localparam logic [2:0] ST_DIFF  = 3'd4;
    localparam logic [2:0] ST_SQR   = 3'd5;
    localparam logic [2:0] ST_CMP   = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    logic [2:0]                state_reg, state_next;
    logic [cpct_pkg::ID_W-1:0] clr_reg, clr_next;
    logic                      mvalid_reg, mvalid_next;
    logic                      out_free;

    assign out_free = !mvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;

    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        mvalid_next    = mvalid_reg && !m_tready;
        cmd.clear      = 1'b0;
        cmd.clear_addr = clr_reg;
        cmd.load       = 1'b0;
        cmd.finish     = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == cpct_pkg::ID_W'(cpct_pkg::MAX_COLLIDERS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: state_next = ST_SUM;
            ST_SUM:   state_next = ST_DIFF;
            ST_DIFF:  state_next = ST_SQR;
            ST_SQR:   state_next = ST_CMP;
            ST_CMP:   state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    cmd.finish  = 1'b1;
                    mvalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            mvalid_reg <= mvalid_next;
        end
    end

endmodule

// File: hdl/cpct_dp.sv
// Datapath: geometry stages, contact row memory and result register.
module cpct_dp (
    input  logic                                aclk,
    input  cpct_pkg::cpct_cmd_t                 cmd,
    input  logic [cpct_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic [cpct_pkg::S_TUSER_W-1:0]      s_tuser,
    output logic [cpct_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [cpct_pkg::M_TUSER_W-1:0]      m_tuser
);

    localparam int GW = cpct_pkg::GEO_W;

    function automatic logic signed [GW-1:0] dbl(input logic [cpct_pkg::POS_W-1:0] p);
        dbl = {{(GW-cpct_pkg::POS_W-1){p[cpct_pkg::POS_W-1]}}, p, 1'b0};
    endfunction

    function automatic logic signed [GW-1:0] ext(input logic [cpct_pkg::POS_W-1:0] p);
        ext = {{(GW-cpct_pkg::POS_W){p[cpct_pkg::POS_W-1]}}, p};
    endfunction

    function automatic logic [GW-1:0] mag(input logic signed [GW-1:0] v);
        mag = v[GW-1] ? GW'(-v) : GW'(v);
    endfunction

    // input transfer
    logic [cpct_pkg::ID_W-1:0]   lid_reg, rid_reg;
    logic [1:0]                  ls_reg, rs_reg;
    logic [cpct_pkg::POS_W-1:0]  lx_reg, ly_reg, rx_reg, ry_reg;
    logic [cpct_pkg::RAW_W-1:0]  lwr_reg, lhr_reg, rwr_reg, rhr_reg;
    logic [cpct_pkg::MAX_COLLIDERS-1:0] row_reg;
    logic [cpct_pkg::MAX_COLLIDERS-1:0] mem [cpct_pkg::MAX_COLLIDERS];

    // pair kind from held inputs
    logic rr, cc, lc_cr, rc_cr, cr;
    assign rr    = (ls_reg == cpct_pkg::SHAPE_RECT)   && (rs_reg == cpct_pkg::SHAPE_RECT);
    assign cc    = (ls_reg == cpct_pkg::SHAPE_CIRCLE) && (rs_reg == cpct_pkg::SHAPE_CIRCLE);
    assign lc_cr = (ls_reg == cpct_pkg::SHAPE_CIRCLE) && (rs_reg == cpct_pkg::SHAPE_RECT);
    assign rc_cr = (ls_reg == cpct_pkg::SHAPE_RECT)   && (rs_reg == cpct_pkg::SHAPE_CIRCLE);
    assign cr    = lc_cr || rc_cr;

    // stage A: scaled sizes
    logic [cpct_pkg::SIZE_W-1:0] lw_a, lh_a, rw_a, rh_a;
    // stage B: far edges (= circle centers), sums, center offsets
    logic signed [GW-1:0] lhx_b, lhy_b, rhx_b, rhy_b, dx_b, dy_b;
    logic [cpct_pkg::SUM_W-1:0] wsum_b, hsum_b;
    // stage C: magnitudes against radius, rect overlaps
    logic [GW-1:0]              mx_c, my_c;
    logic [cpct_pkg::SUM_W-1:0] rad_c;
    logic signed [GW-1:0]       ox_c, oy_c;
    logic                       dxpos_c, dypos_c;
    // stage D: squares
    logic                       far_d;
    logic [cpct_pkg::SQ_W-1:0]  sqx_d, sqy_d, sqr_d;
    logic signed [GW-1:0]       ox_d, oy_d;
    logic                       dxpos_d, dypos_d;
    // stage E: decision
    logic                       hit_e;
    logic [cpct_pkg::POS_W-1:0] depx_e, depy_e;

    // circle-rect operands
    logic signed [GW-1:0] c_x, c_y, lo_x, lo_y, hi_x, hi_y, d1x, d2x, d1y, d2y;
    logic [GW-1:0]        offx, offy;
    always_comb begin
        c_x  = lc_cr ? lhx_b : rhx_b;
        c_y  = lc_cr ? lhy_b : rhy_b;
        lo_x = lc_cr ? dbl(rx_reg) : dbl(lx_reg);
        lo_y = lc_cr ? dbl(ry_reg) : dbl(ly_reg);
        hi_x = lc_cr ? rhx_b : lhx_b;
        hi_y = lc_cr ? rhy_b : lhy_b;
        d1x  = lo_x - c_x;
        d2x  = c_x - hi_x;
        d1y  = lo_y - c_y;
        d2y  = c_y - hi_y;
        offx = (d1x > 0) ? GW'(d1x) : ((d2x > 0) ? GW'(d2x) : '0);
        offy = (d1y > 0) ? GW'(d1y) : ((d2y > 0) ? GW'(d2y) : '0);
    end

    logic [cpct_pkg::POS_W-1:0] mgx, mgy;
    assign mgx = ox_d[cpct_pkg::POS_W:1];
    assign mgy = oy_d[cpct_pkg::POS_W:1];

    always_ff @(posedge aclk) begin
        lw_a <= cpct_pkg::SIZE_W'({7'd0, lwr_reg} * cpct_pkg::SIZE_W'(cpct_pkg::SIZE_SCALE));
        lh_a <= cpct_pkg::SIZE_W'({7'd0, lhr_reg} * cpct_pkg::SIZE_W'(cpct_pkg::SIZE_SCALE));
        rw_a <= cpct_pkg::SIZE_W'({7'd0, rwr_reg} * cpct_pkg::SIZE_W'(cpct_pkg::SIZE_SCALE));
        rh_a <= cpct_pkg::SIZE_W'({7'd0, rhr_reg} * cpct_pkg::SIZE_W'(cpct_pkg::SIZE_SCALE));

        lhx_b  <= dbl(lx_reg) + GW'(lw_a);
        lhy_b  <= dbl(ly_reg) + GW'(lh_a);
        rhx_b  <= dbl(rx_reg) + GW'(rw_a);
        rhy_b  <= dbl(ry_reg) + GW'(rh_a);
        dx_b   <= ext(rx_reg) - ext(lx_reg);
        dy_b   <= ext(ry_reg) - ext(ly_reg);
        wsum_b <= cpct_pkg::SUM_W'(lw_a) + cpct_pkg::SUM_W'(rw_a);
        hsum_b <= cpct_pkg::SUM_W'(lh_a) + cpct_pkg::SUM_W'(rh_a);

        // |d| < 2^32, so doubling it stays inside GW bits
        ox_c    <= $signed(GW'(wsum_b)) - $signed(mag(dx_b) << 1);
        oy_c    <= $signed(GW'(hsum_b)) - $signed(mag(dy_b) << 1);
        dxpos_c <= !dx_b[GW-1] && (dx_b != 0);
        dypos_c <= !dy_b[GW-1] && (dy_b != 0);
        if (cc) begin
            mx_c  <= mag(lhx_b - rhx_b);
            my_c  <= mag(lhy_b - rhy_b);
            rad_c <= wsum_b;
        end else begin
            mx_c  <= offx;
            my_c  <= offy;
            rad_c <= lc_cr ? cpct_pkg::SUM_W'(lw_a) : cpct_pkg::SUM_W'(rw_a);
        end

        far_d   <= (mx_c > GW'(rad_c)) || (my_c > GW'(rad_c));
        sqx_d   <= mx_c[cpct_pkg::SUM_W-1:0] * mx_c[cpct_pkg::SUM_W-1:0];
        sqy_d   <= my_c[cpct_pkg::SUM_W-1:0] * my_c[cpct_pkg::SUM_W-1:0];
        sqr_d   <= rad_c * rad_c;
        ox_d    <= ox_c;
        oy_d    <= oy_c;
        dxpos_d <= dxpos_c;
        dypos_d <= dypos_c;

        if (rr) begin
            hit_e <= (ox_d > 0) && (oy_d > 0);
            // depth only for overlapping rects
            if ((ox_d > 0) && (oy_d > 0)) begin
                depx_e <= dxpos_d ? -mgx : mgx;
                depy_e <= dypos_d ? -mgy : mgy;
            end else begin
                depx_e <= '0;
                depy_e <= '0;
            end
        end else begin
            hit_e  <= (cc || cr) && !far_d &&
                      ({1'b0, sqx_d} + {1'b0, sqy_d} <= {1'b0, sqr_d});
            depx_e <= '0;
            depy_e <= '0;
        end
    end

    // input capture and contact row read
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            lid_reg <= s_tdata[cpct_pkg::ID_W-1:0];
            rid_reg <= s_tdata[6 +: cpct_pkg::ID_W];
            ls_reg  <= s_tuser[1:0];
            rs_reg  <= s_tuser[3:2];
            lx_reg  <= s_tdata[43:12];
            ly_reg  <= s_tdata[75:44];
            lwr_reg <= s_tdata[91:76];
            lhr_reg <= s_tdata[107:92];
            rx_reg  <= s_tdata[139:108];
            ry_reg  <= s_tdata[171:140];
            rwr_reg <= s_tdata[187:172];
            rhr_reg <= s_tdata[203:188];
            row_reg <= mem[s_tdata[cpct_pkg::ID_W-1:0]];
        end
    end

    logic [cpct_pkg::MAX_COLLIDERS-1:0] row_new;
    logic                               prev;
    logic [1:0]                         ev;
    always_comb begin
        row_new          = row_reg;
        row_new[rid_reg] = hit_e;
        prev             = row_reg[rid_reg];
        if (hit_e) begin
            ev = prev ? cpct_pkg::EV_STAY : cpct_pkg::EV_ENTER;
        end else begin
            ev = prev ? cpct_pkg::EV_EXIT : cpct_pkg::EV_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clear) begin
            mem[cmd.clear_addr] <= '0;
        end else if (cmd.finish) begin
            mem[lid_reg] <= row_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_tdata <= {depy_e, depx_e};
            m_tuser <= {hit_e, ev};
        end
    end

endmodule

// File: tb/sv/collider_pair_contact_tracker_top_test.sv
// Self-checking testbench of the collider pair contact tracker top level.
module collider_pair_contact_tracker_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    // One collider pair as it goes into the block.
    typedef struct {
        logic [5:0]  lid, rid;
        logic [1:0]  lshape, rshape;
        logic [31:0] lx, ly, rx, ry;
        logic [15:0] lw, lh, rw, rh;
    } pair_t;

    // One contact result as it comes out.
    typedef struct {
        logic [1:0]  ev;
        logic        hit;
        logic [31:0] dx, dy;
    } contact_t;

    // Directed row: a pair, plus a typed-in result where it is obvious.
    typedef struct {
        pair_t    p;
        bit       typed;
        contact_t r;
    } row_t;

    localparam int RANDOM_ITEMS = 950;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 30;

    logic                            aclk = 0;
    logic                            aresetn = 0;
    logic                            s_tvalid = 0;
    logic                            s_tready;
    logic [cpct_pkg::S_TDATA_W-1:0]  s_tdata = '0;
    logic [cpct_pkg::S_TUSER_W-1:0]  s_tuser = '0;
    logic                            m_tvalid;
    logic                            m_tready = 0;
    logic [cpct_pkg::M_TDATA_W-1:0]  m_tdata;
    logic [cpct_pkg::M_TUSER_W-1:0]  m_tuser;

    collider_pair_contact_tracker_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Predictor state: contact flag per ordered id pair.
    bit       contact_flags [cpct_pkg::MAX_COLLIDERS*cpct_pkg::MAX_COLLIDERS];
    contact_t pending_contacts [$];
    int       mismatches = 0;
    int       cycles = 0;
    int       sent = 0;
    int       phase = 0;          // 0: sender rarely idles, 1: swapped, 2: no idling
    int       hold_off = 0;       // receiver stall, counted down in cycles
    bit       hold_done = 0;

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic bit in_reach(longint ddx, longint ddy, longint r2);
        ddx = mag(ddx);
        ddy = mag(ddy);
        if (ddx > r2 || ddy > r2) return 1'b0;
        return ddx * ddx + ddy * ddy <= r2 * r2;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v;
    endfunction

    // Works out the contact result of one pair and updates the flags.
    function automatic contact_t track_contact(pair_t p);
        contact_t r;
        longint lx, ly, rx, ry, lw, lh, rw, rh;
        longint ddx, ddy, ox, oy, cx, cy, cw, ch, qx, qy, qw, qh, ccx, ccy;
        longint depx, depy;
        int idx;
        bit lc;
        lx = longint'($signed(p.lx)); ly = longint'($signed(p.ly));
        rx = longint'($signed(p.rx)); ry = longint'($signed(p.ry));
        lw = longint'(p.lw) * 100; lh = longint'(p.lh) * 100;
        rw = longint'(p.rw) * 100; rh = longint'(p.rh) * 100;
        r.hit = 1'b0;
        depx = 0;
        depy = 0;
        idx = int'(p.lid) * cpct_pkg::MAX_COLLIDERS + int'(p.rid);
        if (p.lshape == cpct_pkg::SHAPE_RECT && p.rshape == cpct_pkg::SHAPE_RECT) begin
            ddx = rx - lx;
            ddy = ry - ly;
            ox = lw + rw - 2 * mag(ddx);
            oy = lh + rh - 2 * mag(ddy);
            r.hit = (ox > 0) && (oy > 0);
            if (r.hit) begin
                depx = ddx > 0 ? -(ox >>> 1) : (ox >>> 1);
                depy = ddy > 0 ? -(oy >>> 1) : (oy >>> 1);
            end
        end else if (p.lshape == cpct_pkg::SHAPE_CIRCLE &&
                     p.rshape == cpct_pkg::SHAPE_CIRCLE) begin
            r.hit = in_reach((2 * lx + lw) - (2 * rx + rw), (2 * ly + lh) - (2 * ry + rh),
                             lw + rw);
        end else if ((p.lshape == cpct_pkg::SHAPE_CIRCLE &&
                      p.rshape == cpct_pkg::SHAPE_RECT) ||
                     (p.lshape == cpct_pkg::SHAPE_RECT &&
                      p.rshape == cpct_pkg::SHAPE_CIRCLE)) begin
            lc = (p.lshape == cpct_pkg::SHAPE_CIRCLE);
            cx = lc ? lx : rx; cy = lc ? ly : ry;
            cw = lc ? lw : rw; ch = lc ? lh : rh;
            qx = lc ? rx : lx; qy = lc ? ry : ly;
            qw = lc ? rw : lw; qh = lc ? rh : lh;
            ccx = 2 * cx + cw;
            ccy = 2 * cy + ch;
            r.hit = in_reach(ccx - clip(ccx, 2 * qx, 2 * qx + qw),
                             ccy - clip(ccy, 2 * qy, 2 * qy + qh), cw);
        end
        if (r.hit) begin
            r.ev = contact_flags[idx] ? cpct_pkg::EV_STAY : cpct_pkg::EV_ENTER;
            contact_flags[idx] = 1'b1;
        end else if (contact_flags[idx]) begin
            r.ev = cpct_pkg::EV_EXIT;
            contact_flags[idx] = 1'b0;
        end else begin
            r.ev = cpct_pkg::EV_NONE;
        end
        r.dx = depx[31:0];
        r.dy = depy[31:0];
        return r;
    endfunction

    // Offers one pair with a random gap before it, waits for its transfer.
    task automatic offer_pair(pair_t p, bit typed, contact_t typed_r);
        contact_t pr;
        int gap_pct;
        gap_pct = (phase == 0) ? 10 : (phase == 1) ? 69 : 0;
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {p.rshape, p.lshape};
        s_tdata  <= {4'b0, p.rh, p.rw, p.ry, p.rx, p.lh, p.lw, p.ly, p.lx, p.rid, p.lid};
        do @(posedge aclk); while (!s_tready);
        pr = track_contact(p);
        pending_contacts.push_back(typed ? typed_r : pr);
        sent++;
    endtask

    function automatic pair_t mk(int lid, int rid, int ls, int rs,
                                 logic [31:0] lx, logic [31:0] ly, int lw, int lh,
                                 logic [31:0] rx, logic [31:0] ry, int rw, int rh);
        pair_t p;
        p.lid = 6'(lid); p.rid = 6'(rid); p.lshape = 2'(ls); p.rshape = 2'(rs);
        p.lx = lx; p.ly = ly; p.lw = 16'(lw); p.lh = 16'(lh);
        p.rx = rx; p.ry = ry; p.rw = 16'(rw); p.rh = 16'(rh);
        return p;
    endfunction

    function automatic contact_t res(logic [1:0] ev, logic hit, logic [31:0] dx,
                                     logic [31:0] dy);
        contact_t r;
        r.ev = ev; r.hit = hit; r.dx = dx; r.dy = dy;
        return r;
    endfunction

    // Random pair: mostly a few ids and nearby shapes so contacts come and go.
    function automatic pair_t rand_pair();
        pair_t p;
        logic [31:0] bx, by;
        bit near;
        near = $urandom_range(99) < 85;
        p.lid = near ? 6'($urandom_range(3)) : 6'($urandom);
        p.rid = near ? 6'($urandom_range(3)) : 6'($urandom);
        p.lshape = ($urandom_range(9) == 0) ? 2'($urandom) : 2'($urandom_range(1));
        p.rshape = ($urandom_range(9) == 0) ? 2'($urandom) : 2'($urandom_range(1));
        bx = $urandom;
        by = $urandom;
        if (near) begin
            p.lx = bx + 32'($signed($urandom_range(1600)) - 800);
            p.ly = by + 32'($signed($urandom_range(1600)) - 800);
            p.rx = bx + 32'($signed($urandom_range(1600)) - 800);
            p.ry = by + 32'($signed($urandom_range(1600)) - 800);
            p.lw = 16'($urandom_range(8)); p.lh = 16'($urandom_range(8));
            p.rw = 16'($urandom_range(8)); p.rh = 16'($urandom_range(8));
        end else begin
            p.lx = $urandom; p.ly = $urandom; p.rx = $urandom; p.ry = $urandom;
            p.lw = 16'($urandom); p.lh = 16'($urandom);
            p.rw = 16'($urandom); p.rh = 16'($urandom);
        end
        return p;
    endfunction

    // Result checker: each transfer against the oldest expectation.
    always @(posedge aclk) begin
        contact_t want;
        cycles <= cycles + 1;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_contacts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: ev %0d hit %0d", m_tuser[1:0],
                             m_tuser[2]);
            end else begin
                want = pending_contacts.pop_front();
                if (m_tuser[1:0] !== want.ev || m_tuser[2] !== want.hit ||
                    m_tdata[31:0] !== want.dx || m_tdata[63:32] !== want.dy) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: ev %0d/%0d hit %0d/%0d dx %h/%h dy %h/%h",
                                 want.ev, m_tuser[1:0], want.hit, m_tuser[2],
                                 want.dx, m_tdata[31:0], want.dy, m_tdata[63:32]);
                end
            end
        end
    end

    // Receiver: random stalls by phase, one long hold-off to back the block up.
    always @(posedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end else if (phase == 2 && !hold_done && sent >= 700) begin
            hold_done <= 1'b1;
            hold_off  <= 300;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= $urandom_range(99) >= ((phase == 0) ? 69 : (phase == 1) ? 10 : 0);
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    row_t rows [$];

    initial begin
        contact_t none_r;
        none_r = res(cpct_pkg::EV_NONE, 1'b0, 32'd0, 32'd0);
        // Rect pair on one spot: enter, stay, then odd shape codes give exit and none.
        rows.push_back('{mk(0, 0, 0, 0, 0, 0, 1, 1, 0, 0, 1, 1), 1'b1,
                         res(cpct_pkg::EV_ENTER, 1'b1, 32'd100, 32'd100)});
        rows.push_back('{mk(0, 0, 0, 0, 0, 0, 1, 1, 0, 0, 1, 1), 1'b1,
                         res(cpct_pkg::EV_STAY, 1'b1, 32'd100, 32'd100)});
        rows.push_back('{mk(0, 0, 2, 0, 0, 0, 1, 1, 0, 0, 1, 1), 1'b1,
                         res(cpct_pkg::EV_EXIT, 1'b0, 32'd0, 32'd0)});
        rows.push_back('{mk(0, 0, 3, 3, 0, 0, 1, 1, 0, 0, 1, 1), 1'b1, none_r});
        // Zero sizes never overlap as rects (strict compare).
        rows.push_back('{mk(63, 63, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, none_r});
        // Zero-size circles on one spot touch (inclusive compare).
        rows.push_back('{mk(63, 0, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, none_r});
        // Position extremes, far apart.
        rows.push_back('{mk(1, 2, 0, 0, 32'h8000_0000, 32'h8000_0000, 65535, 65535,
                            32'h7fff_ffff, 32'h7fff_ffff, 65535, 65535), 1'b1, none_r});
        rows.push_back('{mk(2, 1, 1, 1, 32'h7fff_ffff, 32'h8000_0000, 65535, 65535,
                            32'h8000_0000, 32'h7fff_ffff, 65535, 65535), 1'b1, none_r});
        // Largest sizes, overlapping rects with signed depths both ways.
        rows.push_back('{mk(5, 6, 0, 0, 0, 0, 65535, 65535, 32'd1000, -32'sd1000,
                            65535, 65535), 1'b0, none_r});
        rows.push_back('{mk(6, 5, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 65535, 65535,
                            32'h7fff_0000, 32'h8000_ffff, 65535, 65535), 1'b0, none_r});
        // Circle against rect in both orders, edge and corner.
        rows.push_back('{mk(7, 8, 1, 0, 0, 0, 2, 2, 32'd200, 0, 1, 1), 1'b0, none_r});
        rows.push_back('{mk(8, 7, 0, 1, 32'd200, 32'd200, 1, 1, 0, 0, 2, 2), 1'b0, none_r});
        rows.push_back('{mk(9, 9, 1, 0, 32'h8000_0000, 32'h7fff_ffff, 65535, 65535,
                            32'h8000_0000, 32'h7fff_ffff, 65535, 65535), 1'b0, none_r});
        rows.push_back('{mk(9, 9, 0, 1, 0, 0, 1, 1, 32'd100000, 0, 1, 1), 1'b0, none_r});
        // Same ids with a shape code of two: may exit, never overlaps.
        rows.push_back('{mk(9, 9, 1, 2, 0, 0, 1, 1, 0, 0, 1, 1), 1'b0, none_r});

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (rows[i]) offer_pair(rows[i].p, rows[i].typed, rows[i].r);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            phase = (n < RANDOM_ITEMS / 3) ? 0 : (n < 2 * RANDOM_ITEMS / 3) ? 1 : 2;
            offer_pair(rand_pair(), 1'b0, none_r);
        end
        s_tvalid <= 1'b0;

        while (pending_contacts.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
